// File: rtl/core/dtpt_pkg.sv
// Package: shared types, codes and constants of the debounced threshold period timer.
package dtpt_pkg;

    localparam int PHASE_WIDTH    = 3;
    localparam int COUNT_WIDTH    = 8;
    localparam int PERIOD_WIDTH   = 32;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int PADDR_WIDTH    = 3;

    localparam int                     THRESHOLD_RESET = 32;
    localparam logic [COUNT_WIDTH-1:0] HITS_RESET      = 8'd5;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_THRESHOLD    = 1'b0,
        REG_SETTLE_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [PHASE_WIDTH-1:0] {
        PH_WAIT_FALL  = 3'd0,
        PH_DEB_FALL   = 3'd1,
        PH_FALL_FOUND = 3'd2,
        PH_WAIT_RISE  = 3'd3,
        PH_DEB_RISE   = 3'd4,
        PH_RISE_FOUND = 3'd5
    } t_phase;

    typedef enum logic [5:0] {
        ST_WAIT_FALL  = 6'b000001,
        ST_DEB_FALL   = 6'b000010,
        ST_FALL_FOUND = 6'b000100,
        ST_WAIT_RISE  = 6'b001000,
        ST_DEB_RISE   = 6'b010000,
        ST_RISE_FOUND = 6'b100000
    } t_state;

    function automatic t_phase state_phase(input t_state st);
        t_phase ph;
        begin
            case (st)
                ST_WAIT_FALL:  ph = PH_WAIT_FALL;
                ST_DEB_FALL:   ph = PH_DEB_FALL;
                ST_FALL_FOUND: ph = PH_FALL_FOUND;
                ST_WAIT_RISE:  ph = PH_WAIT_RISE;
                ST_DEB_RISE:   ph = PH_DEB_RISE;
                ST_RISE_FOUND: ph = PH_RISE_FOUND;
                default:       ph = PH_WAIT_FALL;
            endcase
            return ph;
        end
    endfunction

endpackage

// File: rtl/core/dtpt_if.sv
// Stream interfaces: sample beats in, phase and period beats out.
interface dtpt_sample_if #(
    parameter int SAMPLE_WIDTH = 10,
    parameter int TICK_WIDTH   = 32
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [TICK_WIDTH-1:0]   tick_now;

    modport source (output valid, output sample, output tick_now, input ready);
    modport sink   (input valid, input sample, input tick_now, output ready);
endinterface

interface dtpt_result_if;
    logic                                valid;
    logic                                ready;
    logic [dtpt_pkg::PHASE_WIDTH-1:0]    phase;
    logic                                period_valid;
    logic [dtpt_pkg::PERIOD_WIDTH-1:0]   period_ticks;

    modport source (output valid, output phase, output period_valid, output period_ticks,
                    input ready);
    modport sink   (input valid, input phase, input period_valid, input period_ticks,
                    output ready);
endinterface

// File: rtl/core/debounced_threshold_period_timer.sv
// Top level: debounced threshold-crossing period timer with APB configuration.
//
// Each sample beat is compared with the threshold (below it counts as low) and steps a
// six-state machine: wait for a low sample, debounce the fall over the settle count of
// samples, stamp the fall tick, then the same for the rise. The rise stamp yields the
// period, high time plus low time, modulo 2^TICK_WIDTH and cut or extended to 32 bits.
// Every sample gives exactly one result beat carrying the phase before the step. A sample
// passes the input register, then the result register, and a new sample is taken every
// cycle unless the result side stalls; the state step plus a subtract-and-add on the tick
// marks sits between the two registers. Registers: threshold at byte address 0, settle
// count at 4; write only while idle.
module debounced_threshold_period_timer #(
    parameter int SAMPLE_WIDTH = 10,
    parameter int TICK_WIDTH   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dtpt_sample_if.sink                          i_sample_ch,
    dtpt_result_if.source                        o_result_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dtpt_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [dtpt_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [dtpt_pkg::CFG_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready
);

    localparam int CW = dtpt_pkg::COUNT_WIDTH;
    localparam int PW = dtpt_pkg::PERIOD_WIDTH;
    localparam int DW = dtpt_pkg::CFG_DATA_WIDTH;

    // configuration
    logic [SAMPLE_WIDTH-1:0] r_threshold;
    logic [CW-1:0]           r_hits;
    logic                    w_cfg_wr;
    dtpt_pkg::t_reg_idx      w_reg_idx;

    // input register
    logic                    r_s1_valid;
    logic [SAMPLE_WIDTH-1:0] r_s1_sample;
    logic [TICK_WIDTH-1:0]   r_s1_tick;

    // machine state
    dtpt_pkg::t_state        r_state, n_state;
    logic [CW-1:0]           r_low_count, n_low_count;
    logic [CW-1:0]           r_high_count, n_high_count;
    logic [TICK_WIDTH-1:0]   r_mark_down, n_mark_down;
    logic [TICK_WIDTH-1:0]   r_mark_up, n_mark_up;
    logic [TICK_WIDTH-1:0]   r_time_up, n_time_up;

    // result register
    logic                              r_out_valid;
    logic [dtpt_pkg::PHASE_WIDTH-1:0]  r_out_phase;
    logic                              r_out_pvalid, n_out_pvalid;
    logic [PW-1:0]                     r_out_period, n_out_period;

    logic                    w_out_free;
    logic                    w_adv;
    logic                    w_is_low;
    logic [CW-1:0]           w_low_inc;
    logic [CW-1:0]           w_high_inc;
    logic [TICK_WIDTH-1:0]   w_period;
    logic [TICK_WIDTH+PW-1:0] w_period_ext;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = dtpt_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            dtpt_pkg::REG_THRESHOLD:    prdata = DW'(r_threshold);
            dtpt_pkg::REG_SETTLE_COUNT: prdata = DW'(r_hits);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= SAMPLE_WIDTH'(dtpt_pkg::THRESHOLD_RESET);
            r_hits      <= dtpt_pkg::HITS_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                dtpt_pkg::REG_THRESHOLD:    r_threshold <= pwdata[SAMPLE_WIDTH-1:0];
                dtpt_pkg::REG_SETTLE_COUNT: r_hits      <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshakes
    assign w_out_free        = !r_out_valid || o_result_ch.ready;
    assign w_adv             = r_s1_valid && w_out_free;
    assign i_sample_ch.ready = !r_s1_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample_ch.ready) begin
            r_s1_valid <= i_sample_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample_ch.valid && i_sample_ch.ready) begin
            r_s1_sample <= i_sample_ch.sample;
            r_s1_tick   <= i_sample_ch.tick_now;
        end
    end

    // ---------------------------------------------------------------- step
    assign w_is_low     = r_s1_sample < r_threshold;
    assign w_low_inc    = r_low_count + CW'(1);
    assign w_high_inc   = r_high_count + CW'(1);
    assign w_period     = (r_s1_tick - r_mark_down) + r_time_up;
    assign w_period_ext = {{PW{1'b0}}, w_period};

    always_comb begin
        n_state      = r_state;
        n_low_count  = r_low_count;
        n_high_count = r_high_count;
        n_mark_down  = r_mark_down;
        n_mark_up    = r_mark_up;
        n_time_up    = r_time_up;
        n_out_pvalid = 1'b0;
        n_out_period = '0;
        case (r_state)
            dtpt_pkg::ST_WAIT_FALL: begin
                if (w_is_low) begin
                    n_state      = dtpt_pkg::ST_DEB_FALL;
                    n_low_count  = CW'(1);
                    n_high_count = '0;
                end
            end
            dtpt_pkg::ST_DEB_FALL: begin
                if (w_is_low) begin
                    n_low_count = w_low_inc;
                    if (w_low_inc >= r_hits) begin
                        n_state = dtpt_pkg::ST_FALL_FOUND;
                    end
                end else begin
                    n_low_count = '0;
                end
            end
            dtpt_pkg::ST_FALL_FOUND: begin
                n_mark_down = r_s1_tick;
                n_time_up   = r_s1_tick - r_mark_up;
                n_state     = dtpt_pkg::ST_WAIT_RISE;
            end
            dtpt_pkg::ST_WAIT_RISE: begin
                if (!w_is_low) begin
                    n_state      = dtpt_pkg::ST_DEB_RISE;
                    n_low_count  = '0;
                    n_high_count = CW'(1);
                end
            end
            dtpt_pkg::ST_DEB_RISE: begin
                if (!w_is_low) begin
                    n_high_count = w_high_inc;
                    if (w_high_inc >= r_hits) begin
                        n_state = dtpt_pkg::ST_RISE_FOUND;
                    end
                end else begin
                    n_high_count = '0;
                end
            end
            dtpt_pkg::ST_RISE_FOUND: begin
                n_mark_up    = r_s1_tick;
                n_out_pvalid = 1'b1;
                n_out_period = w_period_ext[PW-1:0];
                n_state      = dtpt_pkg::ST_WAIT_FALL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dtpt_pkg::ST_WAIT_FALL;
            r_low_count  <= '0;
            r_high_count <= '0;
            r_mark_down  <= '0;
            r_mark_up    <= '0;
            r_time_up    <= '0;
        end else if (w_adv) begin
            r_state      <= n_state;
            r_low_count  <= n_low_count;
            r_high_count <= n_high_count;
            r_mark_down  <= n_mark_down;
            r_mark_up    <= n_mark_up;
            r_time_up    <= n_time_up;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_phase  <= dtpt_pkg::state_phase(r_state);
            r_out_pvalid <= n_out_pvalid;
            r_out_period <= n_out_period;
        end
    end

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.phase        = r_out_phase;
    assign o_result_ch.period_valid = r_out_pvalid;
    assign o_result_ch.period_ticks = r_out_period;

    // ---------------------------------------------------------------- assertions
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register lost its one-hot code");

    a_rise_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_state == dtpt_pkg::ST_RISE_FOUND) |=> r_state == dtpt_pkg::ST_WAIT_FALL)
        else $error("rise found did not return to wait fall");

    a_period_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pvalid) |-> r_out_phase == dtpt_pkg::PH_RISE_FOUND)
        else $error("period reported outside rise found");

    a_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_pvalid) |-> r_out_period == '0)
        else $error("period field not cleared without a period");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_ch.ready) |=> r_out_valid && !$past(w_adv))
        else $error("stalled result beat overwritten or dropped");

endmodule

// File: tb/sv/tb_debounced_threshold_period_timer.sv
// Testbench: random and directed sample streams checked beat by beat against a period predictor.
module tb_debounced_threshold_period_timer;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    typedef struct {
        logic [9:0]  level;
        logic [31:0] tick;
    } t_adc_reading;

    typedef struct packed {
        dtpt_pkg::t_phase phase;
        logic             period_valid;
        logic [31:0]      period_ticks;
    } t_period_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [dtpt_pkg::PADDR_WIDTH-1:0]    paddr;
    logic [dtpt_pkg::CFG_DATA_WIDTH-1:0] pwdata;
    logic [dtpt_pkg::CFG_DATA_WIDTH-1:0] prdata;
    logic        pready;

    dtpt_sample_if #(.SAMPLE_WIDTH(10), .TICK_WIDTH(32)) smp_ch ();
    dtpt_result_if res_ch ();

    debounced_threshold_period_timer #(.SAMPLE_WIDTH(10), .TICK_WIDTH(32)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state and its copy of the registers
    dtpt_pkg::t_phase meter_phase;
    logic [7:0]  low_run;
    logic [7:0]  high_run;
    logic [31:0] mark_down;
    logic [31:0] mark_up;
    logic [31:0] time_up;
    logic [9:0]  thr_q;
    logic [7:0]  hits_q;

    t_adc_reading samples_to_send[$];
    t_period_beat period_beats_due[$];

    int          fail_count  = 0;
    int          idle_cycles = 0;
    logic        offer_live  = 1'b0;
    logic        steady_send = 1'b0;
    logic        hold_request = 1'b0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          hold_left   = 0;
    int          pattern_age = 0;
    logic [15:0] stall_pattern;
    logic [31:0] tick_cursor = 32'hFFFF_0000;

    function automatic t_period_beat meter_step(input logic [9:0] smp, input logic [31:0] tick);
        t_period_beat beat;
        logic         is_low;
        is_low = smp < thr_q;
        beat.phase        = meter_phase;
        beat.period_valid = 1'b0;
        beat.period_ticks = '0;
        case (meter_phase)
            dtpt_pkg::PH_WAIT_FALL: begin
                if (is_low) begin
                    meter_phase = dtpt_pkg::PH_DEB_FALL;
                    low_run     = 8'd1;
                    high_run    = 8'd0;
                end
            end
            dtpt_pkg::PH_DEB_FALL: begin
                if (is_low) begin
                    low_run = low_run + 8'd1;
                    if (low_run >= hits_q) meter_phase = dtpt_pkg::PH_FALL_FOUND;
                end else begin
                    low_run = 8'd0;
                end
            end
            dtpt_pkg::PH_FALL_FOUND: begin
                mark_down   = tick;
                time_up     = mark_down - mark_up;
                meter_phase = dtpt_pkg::PH_WAIT_RISE;
            end
            dtpt_pkg::PH_WAIT_RISE: begin
                if (!is_low) begin
                    meter_phase = dtpt_pkg::PH_DEB_RISE;
                    low_run     = 8'd0;
                    high_run    = 8'd1;
                end
            end
            dtpt_pkg::PH_DEB_RISE: begin
                if (!is_low) begin
                    high_run = high_run + 8'd1;
                    if (high_run >= hits_q) meter_phase = dtpt_pkg::PH_RISE_FOUND;
                end else begin
                    high_run = 8'd0;
                end
            end
            dtpt_pkg::PH_RISE_FOUND: begin
                mark_up           = tick;
                beat.period_valid = 1'b1;
                beat.period_ticks = (mark_up - mark_down) + time_up;
                meter_phase       = dtpt_pkg::PH_WAIT_FALL;
            end
            default: ;
        endcase
        return beat;
    endfunction

    function automatic logic [31:0] next_tick();
        tick_cursor = tick_cursor + 32'($urandom_range(1, 3000));
        if ($urandom_range(0, 40) == 0) tick_cursor = $urandom;
        return tick_cursor;
    endfunction

    function automatic logic [9:0] low_level();
        if (thr_q == 10'd0) return 10'($urandom);
        return 10'($urandom_range(0, thr_q - 1));
    endfunction

    function automatic logic [9:0] high_level();
        return 10'($urandom_range(thr_q, 1023));
    endfunction

    function automatic void push_reading(input logic [9:0] level, input logic [31:0] tick);
        t_adc_reading rd;
        rd.level = level;
        rd.tick  = tick;
        samples_to_send.push_back(rd);
    endfunction

    // One debounced run of a level, optionally broken once by a glitch of the other level
    function automatic void push_run(input logic want_low);
        int glitch_at;
        int run_len;
        if ($urandom_range(0, 3) == 0) begin
            glitch_at = $urandom_range(1, (hits_q == 0) ? 1 : hits_q);
            for (int i = 0; i < glitch_at; i++)
                push_reading(want_low ? low_level() : high_level(), next_tick());
            push_reading(want_low ? high_level() : low_level(), next_tick());
        end
        run_len = hits_q + $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++)
            push_reading(want_low ? low_level() : high_level(), next_tick());
    endfunction

    function automatic void fill_waveform(input int n);
        int target;
        target = samples_to_send.size() + n;
        while (samples_to_send.size() < target) begin
            push_run(1'b1);
            push_run(1'b0);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) push_reading(10'($urandom), next_tick());
            end
        end
    endfunction

    task automatic cfg_write(input dtpt_pkg::t_reg_idx idx, input logic [31:0] data);
        logic [31:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == dtpt_pkg::REG_THRESHOLD) thr_q = data[9:0];
        else                                hits_q = data[7:0];
        readback = (idx == dtpt_pkg::REG_THRESHOLD) ? {22'd0, data[9:0]} : {24'd0, data[7:0]};
        // read the register straight back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== readback) begin
            $error("prdata: expected %0h, got %0h", readback, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (samples_to_send.size() != 0 || offer_live || period_beats_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [9:0] thr, input logic [7:0] hits, input int n,
                             input logic long_hold);
        cfg_write(dtpt_pkg::REG_THRESHOLD, {22'($urandom), thr});
        cfg_write(dtpt_pkg::REG_SETTLE_COUNT, {24'($urandom), hits});
        steady_send = long_hold;
        fill_waveform(n);
        if (long_hold) hold_request = 1'b1;
        drain();
        steady_send = 1'b0;
    endtask

    // Sender: offer beats in bursts, hold each until taken
    always @(negedge i_clk) begin
        t_adc_reading rd;
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
        end else if (!offer_live) begin
            if (gap_left != 0) begin
                gap_left--;
                smp_ch.valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
                rd = samples_to_send.pop_front();
                smp_ch.sample   <= rd.level;
                smp_ch.tick_now <= rd.tick;
                smp_ch.valid    <= 1'b1;
                offer_live = 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    if (steady_send || $urandom_range(0, 3) == 0) gap_left = 0;
                    else gap_left = $urandom_range(1, 12);
                end
            end else begin
                smp_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall pattern, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                    pattern_age   = 48;
                end
                pattern_age--;
                res_ch.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && smp_ch.valid && smp_ch.ready) begin
            period_beats_due.push_back(meter_step(smp_ch.sample, smp_ch.tick_now));
            offer_live = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_period_beat due;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (period_beats_due.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                due = period_beats_due.pop_front();
                if (res_ch.phase !== due.phase) begin
                    $error("phase: expected %0d, got %0d", due.phase, res_ch.phase);
                    fail_count++;
                end
                if (res_ch.period_valid !== due.period_valid) begin
                    $error("period_valid: expected %0d, got %0d",
                           due.period_valid, res_ch.period_valid);
                    fail_count++;
                end
                if (res_ch.period_ticks !== due.period_ticks) begin
                    $error("period_ticks: expected %0h, got %0h",
                           due.period_ticks, res_ch.period_ticks);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
        else if (i_rst_n) idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        smp_ch.valid    = 1'b0;
        smp_ch.sample   = '0;
        smp_ch.tick_now = '0;
        res_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        meter_phase     = dtpt_pkg::PH_WAIT_FALL;
        low_run         = '0;
        high_run        = '0;
        mark_down       = '0;
        mark_up         = '0;
        time_up         = '0;
        thr_q           = 10'(dtpt_pkg::THRESHOLD_RESET);
        hits_q          = dtpt_pkg::HITS_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: threshold edge, glitches in both debounces, tick wrap
        push_reading(10'd1023, 32'h0000_0000);
        push_reading(10'd32,   32'h0000_0001);
        push_reading(10'd31,   32'h0000_0002);
        push_reading(10'd0,    32'h0000_0003);
        push_reading(10'd1023, 32'h0000_0004);
        push_reading(10'd0,    32'h0000_0005);
        push_reading(10'd5,    32'h0000_0006);
        push_reading(10'd31,   32'h0000_0007);
        push_reading(10'd0,    32'h0000_0008);
        push_reading(10'd0,    32'h0000_0009);
        push_reading(10'd1023, 32'hFFFF_FFF0);
        push_reading(10'd0,    32'hFFFF_FFF1);
        push_reading(10'd32,   32'hFFFF_FFF2);
        push_reading(10'd1023, 32'hFFFF_FFF3);
        push_reading(10'd512,  32'hFFFF_FFF4);
        push_reading(10'd0,    32'hFFFF_FFF5);
        repeat (5) push_reading(10'd1023, 32'hFFFF_FFFF);
        push_reading(10'd0,    32'h0000_0010);
        push_reading(10'd682,  32'h5555_5555);
        push_reading(10'd341,  32'hAAAA_AAAA);
        drain();

        run_phase(10'd1023, 8'd1,   300, 1'b0);
        run_phase(10'd0,    8'd3,   60,  1'b0);
        // debounce count of zero, with the long hold-off on the result side
        run_phase(10'd512,  8'd0,   300, 1'b1);
        // widest debounce: one full waveform
        run_phase(10'd1,    8'd255, 250, 1'b0);
        repeat (3) run_phase(10'($urandom_range(1, 1023)), 8'($urandom_range(1, 8)), 220, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
